// File: hdl/nnds_pkg.sv
// Package for the nearest-neighbor downscaler: shared constants, register codes and types.
// No dependencies; every other file of the block refers to it by scoped names.
package nnds_pkg;

	localparam int DIM_BITS_DEF = 12;
	localparam int PIX_BITS     = 8;
	localparam int NORM_BITS    = 16;
	localparam int CFG_IDX_BITS = 2;

	// Reset values of the size registers (truncated to DIM_BITS where they are used).
	localparam int SRC_WIDTH_RST  = 160;
	localparam int SRC_HEIGHT_RST = 120;
	localparam int DST_WIDTH_RST  = 128;
	localparam int DST_HEIGHT_RST = 128;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_DST_HEIGHT = 2'd3
	} cfg_reg_t;

	// Decision for the pixel currently in the sampler.
	typedef struct packed {
		logic hit;   // pixel lands on a destination position
		logic last;  // that position is the final one of the destination frame
	} sel_t;

endpackage

// File: hdl/nnds_if.sv
// Channel interfaces of the downscaler: source pixels, results and configuration writes.
// Depends on nnds_pkg for field widths.
interface nnds_pix_if;
	logic                           valid;
	logic                           ready;
	logic [nnds_pkg::PIX_BITS-1:0]  pixel;
	logic                           frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface nnds_res_if;
	logic                           valid;
	logic                           ready;
	logic [nnds_pkg::PIX_BITS-1:0]  raw_pixel;
	logic [nnds_pkg::NORM_BITS-1:0] norm_pixel;
	logic                           last_pixel;

	modport source (output valid, output raw_pixel, output norm_pixel, output last_pixel,
		input ready);
	modport sink   (input valid, input raw_pixel, input norm_pixel, input last_pixel,
		output ready);
endinterface

interface nnds_cfg_if #(
	parameter int DIM_BITS = nnds_pkg::DIM_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic [nnds_pkg::CFG_IDX_BITS-1:0] index;
	logic [DIM_BITS-1:0]               data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/nearest_neighbor_downscale_normalize.sv
// Top level of the nearest-neighbor downscaler with Q1.15 normalization.
// Depends on nnds_pkg, the channel interfaces, nnds_cfg_regs, nnds_sampler and nnds_norm.
//
// Usage:
//   Source pixels arrive in raster order on the src channel, one transaction per pixel,
//   with frame_start set on the first pixel of a frame. Each source pixel produces zero
//   or one transaction on the dst channel, carrying the selected byte, its value divided
//   by 255 in unsigned Q1.15 (rounded), and last_pixel on the final destination pixel.
//   Destination pixel (dx,dy) takes source column floor(dx*W/w) and row floor(dy*H/h).
//   The cfg channel writes the four size registers (index 0..3: source width, source
//   height, destination width, destination height); it is always ready and should only
//   be used while no pixel is in flight.
//
// Timing:
//   A pixel accepted at a clock edge sits in the input register; its result, if any, is
//   loaded into the output register when the stage moves on, which a stalled receiver
//   can delay. One pixel is accepted every cycle unless such a stall holds the stage;
//   the rate is set by the combinational counter and accumulator update in the sampler.
//   When the receiver stalls, the output register holds its transaction; the input
//   register keeps going as long as its pixel produces no result, and otherwise src.ready
//   drops until the output register frees up.
//   Reset clears all counters and both valids and loads 160x120 down to 128x128.
module nearest_neighbor_downscale_normalize #(
	parameter int DIM_BITS = nnds_pkg::DIM_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	nnds_pix_if.sink      src,
	nnds_res_if.source    dst,
	nnds_cfg_if.sink      cfg
);

	logic [DIM_BITS-1:0] src_width, src_height, dst_width, dst_height;

	// Configuration is always accepted.
	assign cfg.ready = 1'b1;

	nnds_cfg_regs #(.DIM_BITS(DIM_BITS)) u_cfg_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg.valid),
		.wr_index   (cfg.index),
		.wr_data    (cfg.data),
		.src_width  (src_width),
		.src_height (src_height),
		.dst_width  (dst_width),
		.dst_height (dst_height)
	);

	// Input register stage.
	logic                          valid_s1;
	logic [nnds_pkg::PIX_BITS-1:0] pixel_s1;
	logic                          start_s1;

	// Output register.
	logic                           out_valid_q;
	logic [nnds_pkg::PIX_BITS-1:0]  raw_q;
	logic [nnds_pkg::NORM_BITS-1:0] norm_q;
	logic                           last_q;

	nnds_pkg::sel_t                 sel;
	logic [nnds_pkg::NORM_BITS-1:0] norm;
	logic                           out_free, s1_go, in_take;

	// The stage may move on when its pixel makes no result, or when the output slot is
	// empty or being emptied in this cycle.
	assign out_free  = !out_valid_q || dst.ready;
	assign s1_go     = valid_s1 && (!sel.hit || out_free);
	assign src.ready = !valid_s1 || s1_go;
	assign in_take   = src.valid && src.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pixel_s1 <= src.pixel;
			start_s1 <= src.frame_start;
		end
	end

	nnds_sampler #(.DIM_BITS(DIM_BITS)) u_sampler (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (s1_go),
		.frame_start (start_s1),
		.src_width   (src_width),
		.src_height  (src_height),
		.dst_width   (dst_width),
		.dst_height  (dst_height),
		.sel         (sel)
	);

	nnds_norm u_norm (
		.pixel (pixel_s1),
		.norm  (norm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && sel.hit) begin
			out_valid_q <= 1'b1;
		end else if (dst.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && sel.hit) begin
			raw_q  <= pixel_s1;
			norm_q <= norm;
			last_q <= sel.last;
		end
	end

	assign dst.valid      = out_valid_q;
	assign dst.raw_pixel  = raw_q;
	assign dst.norm_pixel = norm_q;
	assign dst.last_pixel = last_q;

endmodule

// File: hdl/nnds_cfg_regs.sv
// Size registers of the downscaler, written through the configuration channel.
// Depends on nnds_pkg for register codes and reset values.
module nnds_cfg_regs #(
	parameter int DIM_BITS = nnds_pkg::DIM_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [nnds_pkg::CFG_IDX_BITS-1:0] wr_index,
	input  logic [DIM_BITS-1:0]               wr_data,
	output logic [DIM_BITS-1:0]               src_width,
	output logic [DIM_BITS-1:0]               src_height,
	output logic [DIM_BITS-1:0]               dst_width,
	output logic [DIM_BITS-1:0]               dst_height
);

	logic [DIM_BITS-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= DIM_BITS'(nnds_pkg::SRC_WIDTH_RST);
			src_height_q <= DIM_BITS'(nnds_pkg::SRC_HEIGHT_RST);
			dst_width_q  <= DIM_BITS'(nnds_pkg::DST_WIDTH_RST);
			dst_height_q <= DIM_BITS'(nnds_pkg::DST_HEIGHT_RST);
		end else if (wr_en) begin
			unique case (nnds_pkg::cfg_reg_t'(wr_index))
				nnds_pkg::REG_SRC_WIDTH:  src_width_q  <= wr_data;
				nnds_pkg::REG_SRC_HEIGHT: src_height_q <= wr_data;
				nnds_pkg::REG_DST_WIDTH:  dst_width_q  <= wr_data;
				nnds_pkg::REG_DST_HEIGHT: dst_height_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign src_width  = src_width_q;
	assign src_height = src_height_q;
	assign dst_width  = dst_width_q;
	assign dst_height = dst_height_q;

endmodule

// File: hdl/nnds_sampler.sv
// Position counters and add-only accumulators that pick the nearest source pixel.
// Depends on nnds_pkg for the decision struct.
module nnds_sampler #(
	parameter int DIM_BITS = nnds_pkg::DIM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                frame_start,
	input  logic [DIM_BITS-1:0] src_width,
	input  logic [DIM_BITS-1:0] src_height,
	input  logic [DIM_BITS-1:0] dst_width,
	input  logic [DIM_BITS-1:0] dst_height,
	output nnds_pkg::sel_t      sel
);

	localparam int ACC_BITS = 2 * DIM_BITS;

	logic [DIM_BITS-1:0] src_col_q, src_row_q, dst_col_q, dst_row_q;
	logic [ACC_BITS-1:0] col_src_acc_q, col_dst_acc_q, row_src_acc_q, row_dst_acc_q;

	// State as seen by this pixel: a frame start clears everything first.
	logic [DIM_BITS-1:0] sc, sr, dc, dr;
	logic [ACC_BITS-1:0] csa, cda, rsa, rda;
	logic                row_hit, col_hit, row_end, frame_end;

	logic [DIM_BITS-1:0] sc_n, sr_n, dc_n, dr_n;
	logic [ACC_BITS-1:0] csa_n, cda_n, rsa_n, rda_n;

	always_comb begin
		sc  = frame_start ? '0 : src_col_q;
		sr  = frame_start ? '0 : src_row_q;
		dc  = frame_start ? '0 : dst_col_q;
		dr  = frame_start ? '0 : dst_row_q;
		csa = frame_start ? '0 : col_src_acc_q;
		cda = frame_start ? '0 : col_dst_acc_q;
		rsa = frame_start ? '0 : row_src_acc_q;
		rda = frame_start ? '0 : row_dst_acc_q;

		// dst*src_size < src*dst_size + dst_size, compared one bit wider than the accumulator.
		row_hit = (dr < dst_height) &&
			({1'b0, rda} < ({1'b0, rsa} + (ACC_BITS+1)'(dst_height)));
		col_hit = (dc < dst_width) &&
			({1'b0, cda} < ({1'b0, csa} + (ACC_BITS+1)'(dst_width)));

		sel.hit  = row_hit && col_hit;
		sel.last = (({1'b0, dc} + 1'b1) == {1'b0, dst_width}) &&
			(({1'b0, dr} + 1'b1) == {1'b0, dst_height});

		row_end   = ({1'b0, sc} + 1'b1) >= {1'b0, src_width};
		frame_end = ({1'b0, sr} + 1'b1) >= {1'b0, src_height};
	end

	always_comb begin
		sc_n  = sc;
		sr_n  = sr;
		dc_n  = dc;
		dr_n  = dr;
		csa_n = csa;
		cda_n = cda;
		rsa_n = rsa;
		rda_n = rda;
		if (sel.hit) begin
			dc_n  = dc + 1'b1;
			cda_n = cda + ACC_BITS'(src_width);
		end
		if (row_end) begin
			sc_n  = '0;
			csa_n = '0;
			dc_n  = '0;
			cda_n = '0;
			if (frame_end) begin
				sr_n  = '0;
				dr_n  = '0;
				rsa_n = '0;
				rda_n = '0;
			end else begin
				if (row_hit) begin
					dr_n  = dr + 1'b1;
					rda_n = rda + ACC_BITS'(src_height);
				end
				sr_n  = sr + 1'b1;
				rsa_n = rsa + ACC_BITS'(dst_height);
			end
		end else begin
			sc_n  = sc + 1'b1;
			csa_n = csa + ACC_BITS'(dst_width);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q     <= '0;
			src_row_q     <= '0;
			dst_col_q     <= '0;
			dst_row_q     <= '0;
			col_src_acc_q <= '0;
			col_dst_acc_q <= '0;
			row_src_acc_q <= '0;
			row_dst_acc_q <= '0;
		end else if (step) begin
			src_col_q     <= sc_n;
			src_row_q     <= sr_n;
			dst_col_q     <= dc_n;
			dst_row_q     <= dr_n;
			col_src_acc_q <= csa_n;
			col_dst_acc_q <= cda_n;
			row_src_acc_q <= rsa_n;
			row_dst_acc_q <= rda_n;
		end
	end

endmodule

// File: hdl/nnds_norm.sv
// Pixel normalization to unsigned Q1.15: round(p * 32768 / 255) without a divider.
// Depends on nnds_pkg for field widths.
module nnds_norm (
	input  logic [nnds_pkg::PIX_BITS-1:0]  pixel,
	output logic [nnds_pkg::NORM_BITS-1:0] norm
);

	// 32768 = 128*255 + 128, so the rounded quotient is 128p + floor((128p + 127) / 255).
	// For y below 65535, floor(y / 255) equals (y + 1 + (y >> 8)) >> 8.
	logic [14:0] y;
	logic [15:0] t;
	logic [7:0]  frac;

	always_comb begin
		y    = {pixel, 7'd0} + 15'd127;
		t    = {1'b0, y} + 16'd1 + {9'd0, y[14:8]};
		frac = t[15:8];
		norm = {1'b0, pixel, 7'd0} + {8'd0, frac};
	end

endmodule

// File: hdl/nnds_checker.sv
// Port-level checks for the downscaler and the bind that attaches them to the top level.
// Depends on nnds_pkg for field widths.
module nnds_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [nnds_pkg::PIX_BITS-1:0]  raw_pixel,
	input logic [nnds_pkg::NORM_BITS-1:0] norm_pixel,
	input logic                           last_pixel
);

	// A stalled result transaction keeps its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(raw_pixel) &&
			$stable(norm_pixel) && $stable(last_pixel))
		else $error("result changed while stalled");

	// Normalized value lies between 128p and 128p + 128.
	a_norm_band: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (norm_pixel[15:7] == {1'b0, raw_pixel}) ||
			(norm_pixel == {1'b0, raw_pixel, 7'd0} + 16'd128))
		else $error("normalized value out of band");

	// Black maps to zero and only black does.
	a_norm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((raw_pixel == 8'd0) == (norm_pixel == 16'd0)))
		else $error("zero mapping broken");

	// Full white maps to exactly one.
	a_norm_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && raw_pixel == 8'hFF |-> norm_pixel == 16'h8000)
		else $error("full-scale mapping broken");

endmodule

bind nearest_neighbor_downscale_normalize nnds_checker u_nnds_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (dst.valid),
	.out_ready  (dst.ready),
	.raw_pixel  (dst.raw_pixel),
	.norm_pixel (dst.norm_pixel),
	.last_pixel (dst.last_pixel)
);

// File: verif/nnds_downscale_checker.sv
// Checker for the nearest-neighbor downscaler: predicts and compares every result transaction.
// Depends on nnds_pkg and the channel interfaces in nnds_if.sv.
module nnds_downscale_checker (
	input  logic clk,
	input  logic arst_n,
	nnds_pix_if  src,
	nnds_res_if  dst,
	nnds_cfg_if  cfg,
	output int   mismatches,
	output int   pending
);

	localparam int DIM = nnds_pkg::DIM_BITS_DEF;
	localparam int ACC = 2 * DIM;

	typedef struct packed {
		logic [nnds_pkg::PIX_BITS-1:0]  raw;
		logic [nnds_pkg::NORM_BITS-1:0] norm;
		logic                           last;
	} dst_pixel_t;

	logic [DIM-1:0] src_w, src_h, dst_w, dst_h;
	logic [DIM-1:0] in_col, in_row, out_col, out_row;
	logic [ACC-1:0] in_col_acc, out_col_acc, in_row_acc, out_row_acc;
	dst_pixel_t     awaited_pixels [$];

	function automatic void clear_position();
		in_col      = '0;
		in_row      = '0;
		out_col     = '0;
		out_row     = '0;
		in_col_acc  = '0;
		out_col_acc = '0;
		in_row_acc  = '0;
		out_row_acc = '0;
	endfunction

	// Advances the sampler position by one source pixel and tells whether it lands on
	// a destination position.
	function automatic void pick_pixel(input logic [nnds_pkg::PIX_BITS-1:0] p,
		input logic first, output logic hit, output dst_pixel_t res);
		logic [ACC:0] row_lim, col_lim;
		logic         row_on, col_on;
		int           scaled;
		if (first) begin
			clear_position();
		end
		// The sums are one bit wider so that they cannot wrap before the compare.
		row_lim = {1'b0, in_row_acc} + (ACC+1)'(dst_h);
		col_lim = {1'b0, in_col_acc} + (ACC+1)'(dst_w);
		row_on  = (out_row < dst_h) && ({1'b0, out_row_acc} < row_lim);
		col_on  = (out_col < dst_w) && ({1'b0, out_col_acc} < col_lim);
		hit     = row_on && col_on;
		scaled   = (int'(p) * 32768 + 127) / 255;
		res.raw  = p;
		res.norm = scaled[nnds_pkg::NORM_BITS-1:0];
		res.last = (({1'b0, out_col} + 1'b1) == {1'b0, dst_w}) &&
			(({1'b0, out_row} + 1'b1) == {1'b0, dst_h});
		if (hit) begin
			out_col     = out_col + 1'b1;
			out_col_acc = out_col_acc + ACC'(src_w);
		end
		if (({1'b0, in_col} + 1'b1) >= {1'b0, src_w}) begin
			in_col      = '0;
			in_col_acc  = '0;
			out_col     = '0;
			out_col_acc = '0;
			if (({1'b0, in_row} + 1'b1) >= {1'b0, src_h}) begin
				clear_position();
			end else begin
				if (row_on) begin
					out_row     = out_row + 1'b1;
					out_row_acc = out_row_acc + ACC'(src_h);
				end
				in_row     = in_row + 1'b1;
				in_row_acc = in_row_acc + ACC'(dst_h);
			end
		end else begin
			in_col     = in_col + 1'b1;
			in_col_acc = in_col_acc + ACC'(dst_w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic       hit;
		dst_pixel_t want, got;
		if (!arst_n) begin
			src_w = DIM'(nnds_pkg::SRC_WIDTH_RST);
			src_h = DIM'(nnds_pkg::SRC_HEIGHT_RST);
			dst_w = DIM'(nnds_pkg::DST_WIDTH_RST);
			dst_h = DIM'(nnds_pkg::DST_HEIGHT_RST);
			clear_position();
			awaited_pixels.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (nnds_pkg::cfg_reg_t'(cfg.index))
					nnds_pkg::REG_SRC_WIDTH:  src_w = cfg.data;
					nnds_pkg::REG_SRC_HEIGHT: src_h = cfg.data;
					nnds_pkg::REG_DST_WIDTH:  dst_w = cfg.data;
					nnds_pkg::REG_DST_HEIGHT: dst_h = cfg.data;
					default: ;
				endcase
			end
			if (src.valid && src.ready) begin
				pick_pixel(src.pixel, src.frame_start, hit, want);
				if (hit) begin
					awaited_pixels.push_back(want);
				end
			end
			if (dst.valid && dst.ready) begin
				got = '{dst.raw_pixel, dst.norm_pixel, dst.last_pixel};
				if (awaited_pixels.size() == 0) begin
					mismatches++;
					$display("%0t: expected no result, got raw=%0d norm=%0d last=%0b",
						$time, got.raw, got.norm, got.last);
				end else begin
					want = awaited_pixels.pop_front();
					if (got !== want) begin
						mismatches++;
						$display("%0t: expected raw=%0d norm=%0d last=%0b, got %0d %0d %0b",
							$time, want.raw, want.norm, want.last,
							got.raw, got.norm, got.last);
					end
				end
			end
			pending = awaited_pixels.size();
		end
	end

endmodule

// File: verif/tb_nearest_neighbor_downscale_normalize.sv
// Testbench top for the nearest-neighbor downscaler: clock, reset, stimulus and verdict.
// Depends on nnds_pkg, nnds_if.sv, the block itself and nnds_downscale_checker.
module tb_nearest_neighbor_downscale_normalize;

	localparam int DIM          = nnds_pkg::DIM_BITS_DEF;
	localparam int RANDOM_ITEMS = 1600;
	// The last stretch of random traffic runs with no idling on either side.
	localparam int QUIET_ITEMS  = 200;
	// Far above the slowest correct run: every item waiting out a full sender gap and a
	// full receiver stall, plus the drain before each configuration phase.
	localparam int CYCLE_LIMIT  = 500000;
	localparam logic [3:0] ALL_REGS = '1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int mismatches;
	int pending;
	int sent;
	int cycle_count;
	bit steady;

	// Sizes the block currently holds, as far as the stimulus knows; frames are cut to fit.
	logic [DIM-1:0] sw_now, sh_now, dw_now, dh_now;

	nnds_pix_if                     src_ch ();
	nnds_res_if                     dst_ch ();
	nnds_cfg_if #(.DIM_BITS(DIM))   cfg_ch ();

	nearest_neighbor_downscale_normalize #(.DIM_BITS(DIM)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_ch),
		.dst    (dst_ch),
		.cfg    (cfg_ch)
	);

	nnds_downscale_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src_ch),
		.dst        (dst_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("nearest_neighbor_downscale_normalize regression: fail");
			$finish;
		end
	end

	// Offers one source pixel and waits until the block takes it. Inputs change only at
	// the falling edge; acceptance is judged from the values seen at the rising edge.
	// A random idle burst may come first, but never once the run has gone steady.
	task automatic send_pixel(input logic [nnds_pkg::PIX_BITS-1:0] p, input logic first);
		if (!steady && $urandom_range(0, 3) == 0) begin
			src_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		src_ch.valid       <= 1'b1;
		src_ch.pixel       <= p;
		src_ch.frame_start <= first;
		@(posedge clk);
		while (!src_ch.ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// Stops the source and waits until every predicted result has come out. A pixel that
	// produces nothing can still sit in the input register at that point, so the task goes
	// on waiting afterwards, long enough for that pixel to leave the input register.
	task automatic drain();
		src_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input nnds_pkg::cfg_reg_t idx, input logic [DIM-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes the selected size registers, only once the pipeline is empty. Writes to a
	// subset leave the position counters where they are, which exercises a size change
	// in the middle of a frame.
	task automatic set_sizes(input logic [DIM-1:0] sw, sh, dw, dh, input logic [3:0] sel);
		drain();
		if (sel[nnds_pkg::REG_SRC_WIDTH]) begin
			write_reg(nnds_pkg::REG_SRC_WIDTH, sw);
			sw_now = sw;
		end
		if (sel[nnds_pkg::REG_SRC_HEIGHT]) begin
			write_reg(nnds_pkg::REG_SRC_HEIGHT, sh);
			sh_now = sh;
		end
		if (sel[nnds_pkg::REG_DST_WIDTH]) begin
			write_reg(nnds_pkg::REG_DST_WIDTH, dw);
			dw_now = dw;
		end
		if (sel[nnds_pkg::REG_DST_HEIGHT]) begin
			write_reg(nnds_pkg::REG_DST_HEIGHT, dh);
			dh_now = dh;
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// One whole source frame with random content. A zero width makes every pixel end a
	// row and a zero height makes every row end the frame, hence the floor of one.
	task automatic send_frame(input bit with_start);
		int n;
		n = (sw_now == 0 ? 1 : int'(sw_now)) * (sh_now == 0 ? 1 : int'(sh_now));
		for (int i = 0; i < n; i++) begin
			send_pixel(nnds_pkg::PIX_BITS'($urandom), with_start && i == 0);
		end
	endtask

	// Random pixels with a stray frame start now and then: broken and restarted frames.
	task automatic send_noise(input int len);
		for (int i = 0; i < len; i++) begin
			send_pixel(nnds_pkg::PIX_BITS'($urandom), $urandom_range(0, 9) == 0);
		end
	endtask

	// Result side: ready stays high for a random stretch, sometimes a long one, and then
	// may drop for a stall burst of random length. Stalls stop in the steady stretch.
	initial begin : result_sink
		int span;
		dst_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			dst_ch.ready <= 1'b1;
			span = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
			repeat (span - 1) @(negedge clk);
			if (!steady && $urandom_range(0, 2) == 0) begin
				@(negedge clk);
				dst_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		int             target;
		int             kind;
		logic [DIM-1:0] sw, sh, dw, dh;
		logic [3:0]     sel;

		// Every input is known from time zero, and reset is applied once.
		src_ch.valid       = 1'b0;
		src_ch.pixel       = '0;
		src_ch.frame_start = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = nnds_pkg::REG_SRC_WIDTH;
		cfg_ch.data        = '0;
		sent               = 0;
		steady             = 1'b0;
		sw_now             = DIM'(nnds_pkg::SRC_WIDTH_RST);
		sh_now             = DIM'(nnds_pkg::SRC_HEIGHT_RST);
		dw_now             = DIM'(nnds_pkg::DST_WIDTH_RST);
		dh_now             = DIM'(nnds_pkg::DST_HEIGHT_RST);
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. Reset sizes first (160x120 to 128x128, so the destination is
		// taller than the source), with the pixel byte at its extremes and midpoints.
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h80, 1'b0);
		send_pixel(8'h7F, 1'b0);
		send_pixel(8'h01, 1'b0);
		send_pixel(8'hFE, 1'b0);

		// A 2x2 copy: every pixel is taken and the fourth one is the last of the frame.
		// The fifth pixel has no frame start; the block must have wrapped on its own.
		set_sizes(2, 2, 2, 2, ALL_REGS);
		send_pixel(8'hAA, 1'b1);
		send_pixel(8'h55, 1'b0);
		send_pixel(8'h0F, 1'b0);
		send_pixel(8'hF0, 1'b0);
		send_pixel(8'h33, 1'b0);

		// Destination wider than the source: at most one result per source pixel.
		set_sizes(3, 2, 4, 1, ALL_REGS);
		send_pixel(8'h10, 1'b1);
		send_pixel(8'h20, 1'b0);
		send_pixel(8'h30, 1'b0);
		send_pixel(8'h40, 1'b0);
		send_pixel(8'h50, 1'b0);
		send_pixel(8'h60, 1'b0);

		// Zero destination width: nothing may come out.
		set_sizes(0, 0, 0, 0, 4'(1 << nnds_pkg::REG_DST_WIDTH));
		send_pixel(8'hC3, 1'b1);
		send_pixel(8'h3C, 1'b0);
		send_pixel(8'h99, 1'b0);

		// Zero source sizes: every pixel ends both its row and its frame.
		set_sizes(0, 0, 1, 1, ALL_REGS);
		send_pixel(8'h66, 1'b0);
		send_pixel(8'hE7, 1'b0);
		send_pixel(8'h18, 1'b0);

		// All registers at their largest value.
		set_sizes('1, '1, '1, '1, ALL_REGS);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h00, 1'b0);

		// Random phases. Most use small frames that run to completion so that the last
		// pixel flag is reached often; some ask for a larger destination, some change only
		// part of the sizes, and a few use any 12-bit size with a short burst of pixels.
		target = sent + RANDOM_ITEMS;
		while (sent < target) begin
			steady = (sent >= target - QUIET_ITEMS);
			kind   = $urandom_range(0, 19);
			sw     = DIM'($urandom_range(1, 12));
			sh     = DIM'($urandom_range(1, 8));
			dw     = DIM'($urandom_range(1, int'(sw)));
			dh     = DIM'($urandom_range(1, int'(sh)));
			sel    = ALL_REGS;
			if (kind == 0) begin
				sw = DIM'($urandom);
				sh = DIM'($urandom);
				dw = DIM'($urandom);
				dh = DIM'($urandom);
			end else if (kind == 1) begin
				dw = sw + DIM'($urandom_range(0, 4));
				dh = sh + DIM'($urandom_range(0, 3));
			end else if (kind == 2) begin
				sel = 4'($urandom_range(1, 15));
			end
			set_sizes(sw, sh, dw, dh, sel);
			if (int'(sw_now) * int'(sh_now) > 300) begin
				send_noise($urandom_range(1, 30));
			end else begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 4) != 0) begin
						send_frame($urandom_range(0, 5) != 0);
					end else begin
						send_noise($urandom_range(1, 40));
					end
				end
			end
		end

		// Let the pipeline empty, then wait on for anything unexpected.
		drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("nearest_neighbor_downscale_normalize regression: pass");
		end else begin
			$display("nearest_neighbor_downscale_normalize regression: fail");
		end
		$finish;
	end

endmodule
